// ===== hw/rtl/dsf_pkg.sv =====
// ----------------------------------------------------------------------------
// dsf_pkg: shared types and constants of the damped spring follower
// Holds the sequencer states, unit operation kinds, register indexes and the
// saturate-and-flush helper used by the datapath.
// ----------------------------------------------------------------------------
package dsf_pkg;

    // request modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_PLACE = 2'd1;
    localparam logic [1:0] MODE_KICK  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_STIFFNESS = 3'd0;
    localparam logic [2:0] CFG_DAMPING   = 3'd1;
    localparam logic [2:0] CFG_MASS      = 3'd2;
    localparam logic [2:0] CFG_KICK_DAMP = 3'd3;
    localparam logic [2:0] CFG_KICK_GAIN = 3'd4;
    localparam logic [2:0] CFG_FLUSH     = 3'd5;

    // iteration counts of the divider and square root
    localparam logic [5:0] DIV_STEPS  = 6'd49;
    localparam logic [5:0] SQRT_STEPS = 6'd32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_FORCE,
        ST_ACC,
        ST_SV_ADD,
        ST_SV_MUL,
        ST_KV_ADD,
        ST_KA_MUL,
        ST_KV_MUL,
        ST_VSUM,
        ST_POS,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_NORM,
        ST_KPOW,
        ST_KGAIN,
        ST_DONE
    } t_state;

    typedef enum logic [2:0] {
        K_NONE,
        K_ADD,
        K_MUL,
        K_DIV,
        K_SQ,
        K_SQRT
    } t_kind;

    typedef struct packed {
        logic        clip;
        logic [31:0] val;
    } t_sat;

    // magnitude of a signed 32-bit value, exact for the most negative code
    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    // saturate a sign and magnitude to signed 32 bits, then flush small values
    function automatic t_sat sat_flush(input logic neg, input logic [64:0] m,
                                       input logic [15:0] thr);
        t_sat r;
        r.clip = 1'b0;
        r.val  = '0;
        if (!neg && m > 65'h0_7FFF_FFFF) begin
            r.clip = 1'b1;
            r.val  = 32'h7FFF_FFFF;
        end else if (neg && m > 65'h0_8000_0000) begin
            r.clip = 1'b1;
            r.val  = 32'h8000_0000;
        end else if (m < {49'd0, thr}) begin
            r.val = '0;
        end else begin
            r.val = neg ? (~m[31:0] + 32'd1) : m[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/dsf_req_if.sv =====
// ----------------------------------------------------------------------------
// dsf_req_if: request channel of the damped spring follower
// Valid/ready handshake with mode, targets, start point and kick data.
// ----------------------------------------------------------------------------
interface dsf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [31:0] kick_dir_x;
    logic [31:0] kick_dir_y;
    logic [30:0] kick_power;

    modport src (output valid, mode, target_x, target_y, start_x, start_y,
                 kick_dir_x, kick_dir_y, kick_power, input ready);
    modport snk (input valid, mode, target_x, target_y, start_x, start_y,
                 kick_dir_x, kick_dir_y, kick_power, output ready);
endinterface

// ===== hw/rtl/dsf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dsf_rsp_if: result channel of the damped spring follower
// Valid/ready handshake with the position and the saturation flag.
// ----------------------------------------------------------------------------
interface dsf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        saturated;

    modport src (output valid, pos_x, pos_y, saturated, input ready);
    modport snk (input valid, pos_x, pos_y, saturated, output ready);
endinterface

// ===== hw/rtl/damped_spring_follower.sv =====
// ----------------------------------------------------------------------------
// damped_spring_follower: two-axis damped spring follower, Q16.16 fixed point
// Tick, place and kick requests drive a spring-mass position with a decaying
// kick velocity; one result per request with a saturation flag.
// ----------------------------------------------------------------------------
// One request is worked at a time; i_req.ready is high only while the
// sequencer is idle. A place request or an unused mode goes from the idle
// state straight to ST_DONE and on to the result register. A tick runs each
// axis through a shared 33x32 multiplier, a one-bit-per-cycle restoring
// divider for the mass division (skipped when the mass is zero) and the
// shared adder. A kick squares both direction components, takes a bit-pair
// square root and per axis divides by the length (skipped for a short
// direction) and applies two products. The result register lets the next
// request enter while a result waits to be taken.
// ----------------------------------------------------------------------------
module damped_spring_follower
    import dsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    dsf_req_if.snk      i_req,
    dsf_rsp_if.src      o_rsp
);

    // configuration
    logic [23:0] r_stiff;
    logic [16:0] r_sdamp;
    logic [15:0] r_mass;
    logic [23:0] r_kdamp;
    logic [23:0] r_kgain;
    logic [15:0] r_thr;

    // dynamic state, one entry per axis
    logic [31:0] r_pos [2];
    logic [31:0] r_sv  [2];
    logic [31:0] r_kv  [2];
    logic [31:0] r_ka  [2];

    // captured request
    logic [1:0]  r_mode;
    logic [15:0] r_tgt [2];
    logic [31:0] r_dir [2];
    logic [30:0] r_pow;

    // sequencer and shared unit
    t_state      r_state, n_state;
    logic        r_axis;
    logic        r_phase;
    logic [5:0]  r_cnt;
    logic [31:0] r_tmp;
    logic [31:0] r_len;
    logic [64:0] r_prod;
    logic [48:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] r_root;
    logic [33:0] r_srem;
    logic        r_clip;

    // result register
    logic        r_ovalid;
    logic [31:0] r_opos_x;
    logic [31:0] r_opos_y;
    logic        r_osat;

    // operand selection
    t_kind       kind;
    logic        a_neg;
    logic [47:0] a_mag;
    logic [31:0] m_b;
    logic [31:0] add_x, add_y;
    logic [31:0] den;
    logic        fin;
    logic        short_dir;
    logic        req_fire;
    logic        out_load;

    // datapath
    logic [33:0] diff;
    logic [33:0] diff_mag;
    logic [64:0] prod;
    logic [64:0] rnd;
    logic [32:0] sum;
    logic [32:0] sum_mag;
    logic        res_neg;
    logic [64:0] res_mag;
    t_sat        res;
    logic [48:0] div_init;
    logic [32:0] rem_sh;
    logic        div_ge;
    logic [35:0] sq_rem;
    logic [35:0] sq_trial;
    logic        sq_ge;

    assign req_fire  = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ST_IDLE);
    assign out_load  = (r_state == ST_DONE) && (!r_ovalid || o_rsp.ready);

    assign diff     = {{2{r_tgt[r_axis][15]}}, r_tgt[r_axis], 16'h0}
                    - {{2{r_pos[r_axis][31]}}, r_pos[r_axis]};
    assign diff_mag = diff[33] ? (~diff + 34'd1) : diff;
    assign short_dir = (r_len == 32'd0) || (r_len < {16'd0, r_thr});

    // pick the operation and its operands for the current step
    always_comb begin
        kind  = K_NONE;
        a_neg = 1'b0;
        a_mag = '0;
        m_b   = '0;
        add_x = '0;
        add_y = '0;
        den   = '0;
        unique case (r_state)
            ST_FORCE: begin
                kind  = K_MUL;
                a_neg = diff[33];
                a_mag = {14'd0, diff_mag};
                m_b   = {8'd0, r_stiff};
            end
            ST_ACC: begin
                kind  = (r_mass == 16'd0) ? K_NONE : K_DIV;
                a_neg = r_tmp[31];
                a_mag = {16'd0, abs32(r_tmp)};
                den   = {16'd0, r_mass};
            end
            ST_SV_ADD: begin
                kind  = K_ADD;
                add_x = r_sv[r_axis];
                add_y = r_tmp;
            end
            ST_SV_MUL: begin
                kind  = K_MUL;
                a_neg = r_sv[r_axis][31];
                a_mag = {16'd0, abs32(r_sv[r_axis])};
                m_b   = {15'd0, r_sdamp};
            end
            ST_KV_ADD: begin
                kind  = K_ADD;
                add_x = r_kv[r_axis];
                add_y = r_ka[r_axis];
            end
            ST_KA_MUL: begin
                kind  = K_MUL;
                a_neg = r_ka[r_axis][31];
                a_mag = {16'd0, abs32(r_ka[r_axis])};
                m_b   = {8'd0, r_kdamp};
            end
            ST_KV_MUL: begin
                kind  = K_MUL;
                a_neg = r_kv[r_axis][31];
                a_mag = {16'd0, abs32(r_kv[r_axis])};
                m_b   = {8'd0, r_kdamp};
            end
            ST_VSUM: begin
                kind  = K_ADD;
                add_x = r_sv[r_axis];
                add_y = r_kv[r_axis];
            end
            ST_POS: begin
                kind  = K_ADD;
                add_x = r_pos[r_axis];
                add_y = r_tmp;
            end
            ST_SQX: begin
                kind  = K_SQ;
                a_mag = {16'd0, abs32(r_dir[0])};
                m_b   = abs32(r_dir[0]);
            end
            ST_SQY: begin
                kind  = K_SQ;
                a_mag = {16'd0, abs32(r_dir[1])};
                m_b   = abs32(r_dir[1]);
            end
            ST_SQRT: begin
                kind = K_SQRT;
            end
            ST_NORM: begin
                kind  = short_dir ? K_NONE : K_DIV;
                a_neg = r_dir[r_axis][31];
                a_mag = {abs32(r_dir[r_axis]), 16'h0};
                den   = r_len;
            end
            ST_KPOW: begin
                kind  = K_MUL;
                a_neg = r_tmp[31];
                a_mag = {16'd0, abs32(r_tmp)};
                m_b   = {1'b0, r_pow};
            end
            ST_KGAIN: begin
                kind  = K_MUL;
                a_neg = r_tmp[31];
                a_mag = {16'd0, abs32(r_tmp)};
                m_b   = {8'd0, r_kgain};
            end
            default: begin
                kind = K_NONE;
            end
        endcase
    end

    // shared multiplier, adder, divider step and square-root step
    assign prod     = 65'(a_mag[32:0]) * 65'(m_b);
    assign rnd      = (r_prod + 65'd32768) >> 16;
    assign sum      = {add_x[31], add_x} + {add_y[31], add_y};
    assign sum_mag  = sum[32] ? (~sum + 33'd1) : sum;
    assign div_init = {1'b0, a_mag} + {17'd0, 1'b0, den[31:1]};
    assign rem_sh   = {r_rem, r_num[48]};
    assign div_ge   = rem_sh >= {1'b0, den};
    assign sq_rem   = {r_srem, r_prod[63:62]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;

    always_comb begin
        res_neg = a_neg;
        res_mag = '0;
        case (kind)
            K_ADD: begin
                res_neg = sum[32];
                res_mag = {32'd0, sum_mag};
            end
            K_MUL:   res_mag = rnd;
            K_DIV:   res_mag = {16'd0, r_num};
            default: res_mag = '0;
        endcase
        res = sat_flush(res_neg, res_mag, r_thr);
    end

    always_comb begin
        case (kind) inside
            K_MUL:         fin = r_phase;
            K_DIV, K_SQRT: fin = r_phase && (r_cnt == 6'd0);
            default:       fin = 1'b1;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (req_fire) begin
                    if (i_req.mode == MODE_TICK) begin
                        n_state = ST_FORCE;
                    end else if (i_req.mode == MODE_KICK) begin
                        n_state = ST_SQX;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_FORCE:  if (fin) n_state = ST_ACC;
            ST_ACC:    if (fin) n_state = ST_SV_ADD;
            ST_SV_ADD: if (fin) n_state = ST_SV_MUL;
            ST_SV_MUL: if (fin) n_state = ST_KV_ADD;
            ST_KV_ADD: if (fin) n_state = ST_KA_MUL;
            ST_KA_MUL: if (fin) n_state = ST_KV_MUL;
            ST_KV_MUL: if (fin) n_state = ST_VSUM;
            ST_VSUM:   if (fin) n_state = ST_POS;
            ST_POS:    if (fin) n_state = r_axis ? ST_DONE : ST_FORCE;
            ST_SQX:    if (fin) n_state = ST_SQY;
            ST_SQY:    if (fin) n_state = ST_SQRT;
            ST_SQRT:   if (fin) n_state = ST_NORM;
            ST_NORM:   if (fin) n_state = ST_KPOW;
            ST_KPOW:   if (fin) n_state = ST_KGAIN;
            ST_KGAIN:  if (fin) n_state = r_axis ? ST_DONE : ST_NORM;
            ST_DONE:   if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stiff <= 24'd65536;
            r_sdamp <= 17'd65536;
            r_mass  <= 16'd100;
            r_kdamp <= 24'd65536;
            r_kgain <= 24'd65536;
            r_thr   <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STIFFNESS: r_stiff <= i_cfg_data;
                CFG_DAMPING:   r_sdamp <= i_cfg_data[16:0];
                CFG_MASS:      r_mass  <= i_cfg_data[15:0];
                CFG_KICK_DAMP: r_kdamp <= i_cfg_data;
                CFG_KICK_GAIN: r_kgain <= i_cfg_data;
                CFG_FLUSH:     r_thr   <= i_cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    // capture the request
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_mode   <= i_req.mode;
            r_tgt[0] <= i_req.target_x;
            r_tgt[1] <= i_req.target_y;
            r_dir[0] <= i_req.kick_dir_x;
            r_dir[1] <= i_req.kick_dir_y;
            r_pow    <= i_req.kick_power;
        end
    end

    // unit control: phase, counter and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
            r_clip  <= 1'b0;
        end else if (req_fire) begin
            r_phase <= 1'b0;
            r_axis  <= 1'b0;
            r_clip  <= 1'b0;
        end else if (r_state != ST_IDLE && r_state != ST_DONE) begin
            if (fin) begin
                r_phase <= 1'b0;
                if (kind == K_ADD || kind == K_MUL || kind == K_DIV) begin
                    r_clip <= r_clip | res.clip;
                end
                if ((r_state == ST_POS || r_state == ST_KGAIN) && !r_axis) begin
                    r_axis <= 1'b1;
                end
            end else begin
                r_phase <= 1'b1;
                if (!r_phase) begin
                    r_cnt <= (kind == K_DIV) ? DIV_STEPS : SQRT_STEPS;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    // product register, divider and square-root working registers
    always_ff @(posedge i_clk) begin
        case (kind)
            K_MUL: begin
                if (!r_phase) r_prod <= prod;
            end
            K_SQ: begin
                r_prod <= (r_state == ST_SQX) ? prod : (r_prod + prod);
            end
            K_DIV: begin
                if (!r_phase) begin
                    r_num <= div_init;
                    r_rem <= '0;
                end else if (r_cnt != 6'd0) begin
                    r_rem <= div_ge ? 32'(rem_sh - {1'b0, den}) : rem_sh[31:0];
                    r_num <= {r_num[47:0], div_ge};
                end
            end
            K_SQRT: begin
                if (!r_phase) begin
                    r_srem <= '0;
                    r_root <= '0;
                end else if (r_cnt != 6'd0) begin
                    r_srem <= sq_ge ? 34'(sq_rem - sq_trial) : sq_rem[33:0];
                    r_root <= {r_root[30:0], sq_ge};
                    r_prod <= {r_prod[62:0], 2'b00};
                end else begin
                    r_len <= r_root;
                end
            end
            default: ;
        endcase
    end

    // write results back to the state and scratch registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2; i++) begin
                r_pos[i] <= '0;
                r_sv[i]  <= '0;
                r_kv[i]  <= '0;
                r_ka[i]  <= '0;
            end
        end else if (req_fire) begin
            if (i_req.mode == MODE_PLACE) begin
                r_pos[0] <= {i_req.start_x, 16'h0};
                r_pos[1] <= {i_req.start_y, 16'h0};
            end
        end else if (fin) begin
            case (r_state)
                ST_FORCE:  r_tmp <= res.val;
                ST_ACC:    if (kind == K_DIV) r_tmp <= res.val;
                ST_SV_ADD: r_sv[r_axis] <= res.val;
                ST_SV_MUL: r_sv[r_axis] <= res.val;
                ST_KV_ADD: r_kv[r_axis] <= res.val;
                ST_KA_MUL: r_ka[r_axis] <= res.val;
                ST_KV_MUL: r_kv[r_axis] <= res.val;
                ST_VSUM:   r_tmp <= res.val;
                ST_POS:    r_pos[r_axis] <= res.val;
                ST_NORM:   r_tmp <= short_dir ? r_dir[r_axis] : res.val;
                ST_KPOW:   r_tmp <= res.val;
                ST_KGAIN:  r_ka[r_axis] <= res.val;
                default:   ;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_opos_x <= r_pos[0];
            r_opos_y <= r_pos[1];
            r_osat   <= (r_mode == MODE_TICK || r_mode == MODE_KICK) ? r_clip : 1'b0;
        end
    end

    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.pos_x     = r_opos_x;
    assign o_rsp.pos_y     = r_opos_y;
    assign o_rsp.saturated = r_osat;

`ifndef SYNTH
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_req.ready)
        else $error("request taken while sequencer busy");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (o_rsp.valid && r_state == ST_IDLE))
        else $error("finished request did not reach the result register");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DIV_STEPS)
        else $error("iteration counter out of range");

    a_phase_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (kind == K_MUL || kind == K_DIV || kind == K_SQRT))
        else $error("unit phase set outside a multi-cycle step");
`endif

endmodule

// ===== tb/damped_spring_follower_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damped_spring_follower_tb: self-checking bench of the damped spring follower
// Walks a short table of directed requests, then runs phases of random ticks,
// places and kicks under changing coefficients. Each request is fed to an
// in-bench fixed-point follower, and every result is compared with the oldest
// predicted position and saturation flag. Both handshake sides stall randomly.
// ----------------------------------------------------------------------------
module damped_spring_follower_tb
    import dsf_pkg::*;
();

    // mode code with no operation behind it
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         N_PHASES    = 10;
    localparam int         PHASE_REQS  = 154;

    typedef struct {
        logic [1:0]  mode;
        logic [15:0] tgt_x, tgt_y, st_x, st_y;
        logic [31:0] dir_x, dir_y;
        logic [30:0] power;
        bit          typed;
        logic [31:0] want_x, want_y;
        logic        want_sat;
    } t_req_row;

    typedef struct {
        logic [31:0] pos_x, pos_y;
        logic        sat;
    } t_pos_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [23:0] i_cfg_data;

    dsf_req_if req_ch();
    dsf_rsp_if rsp_ch();

    damped_spring_follower uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.snk),
        .o_rsp      (rsp_ch.src)
    );

    // ------------------------------------------------------------------
    // follower model: coefficients, state and per-request clip flag
    // ------------------------------------------------------------------
    longint unsigned cf_stiff, cf_damp, cf_mass, cf_kdamp, cf_kgain, cf_thr;
    int  fw_pos_x, fw_pos_y, fw_sv_x, fw_sv_y, fw_kv_x, fw_kv_y, fw_ka_x, fw_ka_y;
    bit  fw_clip;

    t_pos_result pos_expect_q[$];
    int  n_errors;
    bit  calm;          // when set, neither side idles

    function automatic longint unsigned magn(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic int flush_q(int v);
        return (magn(longint'(v)) < cf_thr) ? 0 : v;
    endfunction

    function automatic int sat_q(bit neg, longint unsigned m);
        if (!neg && m > 64'h7FFF_FFFF) begin
            fw_clip = 1'b1;
            return 32'sh7FFF_FFFF;
        end
        if (neg && m > 64'h8000_0000) begin
            fw_clip = 1'b1;
            return 32'sh8000_0000;
        end
        return neg ? int'(-longint'(m)) : int'(longint'(m));
    endfunction

    function automatic int add_q(int a, int b);
        longint s;
        s = longint'(a) + longint'(b);
        return flush_q(sat_q(s < 0, magn(s)));
    endfunction

    function automatic int mul_q(longint a, longint unsigned b);
        longint unsigned r;
        r = (magn(a) * b + 64'd32768) >> 16;
        return flush_q(sat_q(a < 0, r));
    endfunction

    function automatic int div_q(longint num, longint unsigned den);
        longint unsigned r;
        r = (magn(num) + den / 2) / den;
        return flush_q(sat_q(num < 0, r));
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    task automatic spring_step(input logic [15:0] tgt, inout int pos, inout int sv);
        longint diff;
        int     force_v, acc;
        diff    = longint'($signed(tgt)) * 65536 - longint'(pos);
        force_v = mul_q(diff, cf_stiff);
        acc     = (cf_mass != 0) ? div_q(longint'(force_v), cf_mass) : force_v;
        sv      = add_q(sv, acc);
        sv      = mul_q(longint'(sv), cf_damp);
    endtask

    task automatic kick_step(inout int kv, inout int ka);
        kv = add_q(kv, ka);
        ka = mul_q(longint'(ka), cf_kdamp);
        kv = mul_q(longint'(kv), cf_kdamp);
    endtask

    task automatic advance_follower(input t_req_row r, output t_pos_result res);
        longint dx, dy;
        longint unsigned len;
        int nx, ny;
        fw_clip = 1'b0;
        case (r.mode)
            MODE_TICK: begin
                spring_step(r.tgt_x, fw_pos_x, fw_sv_x);
                spring_step(r.tgt_y, fw_pos_y, fw_sv_y);
                kick_step(fw_kv_x, fw_ka_x);
                kick_step(fw_kv_y, fw_ka_y);
                fw_pos_x = add_q(fw_pos_x, add_q(fw_sv_x, fw_kv_x));
                fw_pos_y = add_q(fw_pos_y, add_q(fw_sv_y, fw_kv_y));
            end
            MODE_PLACE: begin
                fw_pos_x = int'(longint'($signed(r.st_x)) * 65536);
                fw_pos_y = int'(longint'($signed(r.st_y)) * 65536);
            end
            MODE_KICK: begin
                dx  = longint'($signed(r.dir_x));
                dy  = longint'($signed(r.dir_y));
                len = root_floor(magn(dx) * magn(dx) + magn(dy) * magn(dy));
                // short direction: use it as given
                if (len == 0 || len < cf_thr) begin
                    nx = int'(dx);
                    ny = int'(dy);
                end else begin
                    nx = div_q(dx * 65536, len);
                    ny = div_q(dy * 65536, len);
                end
                fw_ka_x = mul_q(longint'(mul_q(longint'(nx), r.power)), cf_kgain);
                fw_ka_y = mul_q(longint'(mul_q(longint'(ny), r.power)), cf_kgain);
            end
            default: ;
        endcase
        res.pos_x = fw_pos_x;
        res.pos_y = fw_pos_y;
        res.sat   = fw_clip;
    endtask

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** damped_spring_follower: FAILED **");
        $finish;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // ------------------------------------------------------------------
    // result side: random stalls at the falling edge, checks at the rising
    // ------------------------------------------------------------------
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end else begin
            stall_left = pick_gap();
            rsp_ch.ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        t_pos_result want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pos_expect_q.size() == 0) begin
                $display("%0t: result with no request pending: pos_x %h pos_y %h sat %b",
                         $time, rsp_ch.pos_x, rsp_ch.pos_y, rsp_ch.saturated);
                n_errors++;
            end else begin
                want = pos_expect_q.pop_front();
                if (rsp_ch.pos_x !== want.pos_x) begin
                    $display("%0t: pos_x expected %h actual %h",
                             $time, want.pos_x, rsp_ch.pos_x);
                    n_errors++;
                end
                if (rsp_ch.pos_y !== want.pos_y) begin
                    $display("%0t: pos_y expected %h actual %h",
                             $time, want.pos_y, rsp_ch.pos_y);
                    n_errors++;
                end
                if (rsp_ch.saturated !== want.sat) begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, rsp_ch.saturated);
                    n_errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------
    // Hold the request until accepted; predict it at the accepting edge.
    task automatic send_request(input t_req_row r);
        t_pos_result res;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.mode       = r.mode;
        req_ch.target_x   = r.tgt_x;
        req_ch.target_y   = r.tgt_y;
        req_ch.start_x    = r.st_x;
        req_ch.start_y    = r.st_y;
        req_ch.kick_dir_x = r.dir_x;
        req_ch.kick_dir_y = r.dir_y;
        req_ch.kick_power = r.power;
        req_ch.valid      = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        advance_follower(r, res);
        // table rows with a typed answer take it over the model
        if (r.typed) begin
            res.pos_x = r.want_x;
            res.pos_y = r.want_y;
            res.sat   = r.want_sat;
        end
        pos_expect_q.push_back(res);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint unsigned val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val[23:0];
        case (idx)
            CFG_STIFFNESS: cf_stiff = val & 64'hFF_FFFF;
            CFG_DAMPING:   cf_damp  = val & 64'h1_FFFF;
            CFG_MASS:      cf_mass  = val & 64'hFFFF;
            CFG_KICK_DAMP: cf_kdamp = val & 64'hFF_FFFF;
            CFG_KICK_GAIN: cf_kgain = val & 64'hFF_FFFF;
            CFG_FLUSH:     cf_thr   = val & 64'hFFFF;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Drain: wait until every result is back, then let the block settle.
    task automatic drain();
        req_ch.valid = 1'b0;
        wait (pos_expect_q.size() == 0);
        repeat (200) @(negedge i_clk);
    endtask

    function automatic t_req_row mk_row(logic [1:0] mode, logic [15:0] tx, logic [15:0] ty,
                                        logic [15:0] sx, logic [15:0] sy,
                                        logic [31:0] dx, logic [31:0] dy, logic [30:0] pw);
        t_req_row r;
        r.mode = mode;  r.tgt_x = tx; r.tgt_y = ty; r.st_x = sx; r.st_y = sy;
        r.dir_x = dx;   r.dir_y = dy; r.power = pw;
        r.typed = 1'b0; r.want_x = '0; r.want_y = '0; r.want_sat = 1'b0;
        return r;
    endfunction

    function automatic t_req_row with_answer(t_req_row r, logic [31:0] ex, logic [31:0] ey);
        r.typed = 1'b1; r.want_x = ex; r.want_y = ey; r.want_sat = 1'b0;
        return r;
    endfunction

    // mostly modest targets and directions, sometimes the full range
    function automatic t_req_row random_row();
        t_req_row r;
        int p;
        logic [1:0] mode;
        p = $urandom_range(99);
        if (p < 70)      mode = MODE_TICK;
        else if (p < 82) mode = MODE_PLACE;
        else if (p < 96) mode = MODE_KICK;
        else             mode = MODE_UNUSED;
        r = mk_row(mode, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   $urandom, $urandom, 31'($urandom));
        if ($urandom_range(3) != 0) begin
            r.tgt_x = 16'($signed($urandom_range(400)) - 200);
            r.tgt_y = 16'($signed($urandom_range(400)) - 200);
            r.st_x  = 16'($signed($urandom_range(400)) - 200);
            r.st_y  = 16'($signed($urandom_range(400)) - 200);
            r.dir_x = 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
            r.dir_y = 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
            r.power = 31'($urandom_range(32'h30000));
        end
        return r;
    endfunction

    function automatic longint unsigned pick_coef(longint unsigned top, longint unsigned usual);
        int p;
        p = $urandom_range(9);
        if (p == 0) return 0;
        if (p == 1) return top;
        return 64'($urandom_range(32'(usual)));
    endfunction

    t_req_row dir_table[$];

    initial begin
        t_req_row r;
        n_errors     = 0;
        calm         = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_STIFFNESS;
        i_cfg_data   = '0;
        req_ch.valid = 1'b0;
        r = mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
        req_ch.mode = r.mode; req_ch.target_x = '0; req_ch.target_y = '0;
        req_ch.start_x = '0;  req_ch.start_y = '0;  req_ch.kick_dir_x = '0;
        req_ch.kick_dir_y = '0; req_ch.kick_power = '0;
        rsp_ch.ready = 1'b0;

        // reset values of the coefficients and state
        cf_stiff = 65536; cf_damp = 65536; cf_mass = 100;
        cf_kdamp = 65536; cf_kgain = 65536; cf_thr = 1;
        fw_pos_x = 0; fw_pos_y = 0; fw_sv_x = 0; fw_sv_y = 0;
        fw_kv_x = 0;  fw_kv_y = 0;  fw_ka_x = 0; fw_ka_y = 0;

        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: extremes of every field, every mode, short kicks
        dir_table.push_back(with_answer(mk_row(MODE_PLACE, 0, 0, 16'h7FFF, 16'h8000, 0, 0, 0),
                                        32'h7FFF_0000, 32'h8000_0000));
        dir_table.push_back(with_answer(mk_row(MODE_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                               16'hFFFF, '1, '1, '1),
                                        32'h7FFF_0000, 32'h8000_0000));
        dir_table.push_back(with_answer(mk_row(MODE_PLACE, 0, 0, 16'hFFFF, 16'h0001, 0, 0, 0),
                                        32'hFFFF_0000, 32'h0001_0000));
        dir_table.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_TICK, 16'h7FFF, 16'h8000, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_TICK, 16'h8000, 16'h7FFF, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_KICK, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
        dir_table.push_back(mk_row(MODE_KICK, 0, 0, 0, 0, 32'h1, 32'hFFFF_FFFF, 31'h1_0000));
        dir_table.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_KICK, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                                   31'h7FFF_FFFF));
        dir_table.push_back(mk_row(MODE_TICK, 16'h0064, 16'hFF9C, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_KICK, 0, 0, 0, 0, 32'h0001_0000, 0, 31'h1_0000));
        dir_table.push_back(mk_row(MODE_TICK, 0, 0, 0, 0, 0, 0, 0));
        dir_table.push_back(mk_row(MODE_TICK, 16'h0005, 16'h0005, 0, 0, 0, 0, 0));
        dir_table.push_back(with_answer(mk_row(MODE_PLACE, 0, 0, 0, 0, 0, 0, 0), 0, 0));
        dir_table.push_back(mk_row(MODE_TICK, 16'hFFFB, 16'h0003, 0, 0, 0, 0, 0));
        foreach (dir_table[i]) send_request(dir_table[i]);

        // random phases: fresh coefficients each time, extremes in the first few
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            calm = (ph % 4 == 3);
            case (ph)
                0: begin        // zero mass, damping above one, no flush
                    write_reg(CFG_STIFFNESS, 24'h00_8000);
                    write_reg(CFG_DAMPING, 17'h1_FFFF);
                    write_reg(CFG_MASS, 0);
                    write_reg(CFG_KICK_DAMP, 24'hFF_FFFF);
                    write_reg(CFG_KICK_GAIN, 24'hFF_FFFF);
                    write_reg(CFG_FLUSH, 0);
                end
                1: begin        // dead spring, top flush threshold
                    write_reg(CFG_STIFFNESS, 0);
                    write_reg(CFG_DAMPING, 0);
                    write_reg(CFG_MASS, 16'hFFFF);
                    write_reg(CFG_KICK_DAMP, 0);
                    write_reg(CFG_KICK_GAIN, 0);
                    write_reg(CFG_FLUSH, 16'hFFFF);
                end
                2: begin        // stiffest spring, unit mass
                    write_reg(CFG_STIFFNESS, 24'hFF_FFFF);
                    write_reg(CFG_DAMPING, 17'h1_0000);
                    write_reg(CFG_MASS, 1);
                    write_reg(CFG_KICK_DAMP, 24'h00_F000);
                    write_reg(CFG_KICK_GAIN, 24'h01_0000);
                    write_reg(CFG_FLUSH, 1);
                end
                default: begin
                    write_reg(CFG_STIFFNESS, pick_coef(24'hFF_FFFF, 24'h04_0000));
                    write_reg(CFG_DAMPING, pick_coef(17'h1_0000, 17'h1_0000));
                    write_reg(CFG_MASS, pick_coef(16'hFFFF, 200) | 1);
                    write_reg(CFG_KICK_DAMP, pick_coef(24'hFF_FFFF, 24'h01_0000));
                    write_reg(CFG_KICK_GAIN, pick_coef(24'hFF_FFFF, 24'h02_0000));
                    write_reg(CFG_FLUSH, pick_coef(16'hFFFF, 64));
                end
            endcase
            for (int k = 0; k < PHASE_REQS; k++) send_request(random_row());
        end

        drain();
        if (n_errors == 0) begin
            $display("** damped_spring_follower: PASSED **");
        end else begin
            $display("** damped_spring_follower: FAILED **");
        end
        $finish;
    end

endmodule
